FILE: hdl/pls_pkg.sv
package pls_pkg;

    // Thresholds of the shading arithmetic
    localparam int unsigned MIN_NORM_SQ = 1;
    localparam int unsigned MIN_DIST_SQ = 4096;

    localparam logic [15:0] ONE_Q15 = 16'd32768;
    localparam logic [23:0] MAX_OUT = 24'hFF_FFFF;

    // Normaliser: 31 root steps over a 62-bit word, 15 quotient bits
    localparam int NORM_SQRT_STEPS = 31;
    localparam int NORM_DIV_STEPS  = 15;
    localparam int NORM_LAT        = 3 + NORM_SQRT_STEPS + 1 + NORM_DIV_STEPS + 1;

    // Falloff divider: quotient bits follow from the distance clamp
    localparam int FALL_QW  = 37 - $clog2(MIN_DIST_SQ + 1);
    localparam int FALL_SW  = $clog2(FALL_QW);
    localparam int FALL_DW  = 36 + FALL_QW;
    localparam int FALL_LAT = FALL_QW + 3;

    // Power unit: 8 integer bits, 8 fraction bits each with a 16 step root
    localparam int POW_INT_BITS   = 8;
    localparam int POW_FRAC_BITS  = 8;
    localparam int POW_ROOT_STEPS = 16;
    localparam int POW_LAT        = 1 + POW_INT_BITS
                                    + POW_FRAC_BITS * (POW_ROOT_STEPS + 1) + 1;

    typedef logic signed [23:0] raw_vec_t [3];
    typedef logic signed [15:0] unit_vec_t [3];
    typedef logic [2:0][23:0]   rgb_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_DIFFUSE_RED    = 3'd0,
        REG_DIFFUSE_GREEN  = 3'd1,
        REG_DIFFUSE_BLUE   = 3'd2,
        REG_SPECULAR_RED   = 3'd3,
        REG_SPECULAR_GREEN = 3'd4,
        REG_SPECULAR_BLUE  = 3'd5,
        REG_SHINE_EXPONENT = 3'd6,
        REG_LIGHT_KIND     = 3'd7
    } cfg_reg_t;

endpackage

FILE: hdl/pls_unit_vec.sv
module pls_unit_vec
    import pls_pkg::*;
(
    input  logic      aclk,
    input  logic      en,
    input  raw_vec_t  comp_in,
    output unit_vec_t unit_out
);

    typedef struct packed {
        logic [61:0]      rem;
        logic [61:0]      root;
        logic [2:0][23:0] mag;
        logic [2:0]       neg;
        logic [4:0]       expo;
        logic             zero;
    } sq_t;

    typedef struct packed {
        logic [2:0][45:0] rem;
        logic [2:0][14:0] quo;
        logic [30:0]      q;
        logic [2:0]       neg;
        logic             zero;
    } dv_t;

    logic [2:0][23:0] mag_c;
    logic [2:0]       neg_c;
    logic [47:0]      sum_c;
    logic [5:0]       msb_c;

    logic [47:0]      sum1_reg;
    logic [2:0][23:0] mag1_reg;
    logic [2:0]       neg1_reg;
    logic [47:0]      sum2_reg;
    logic [4:0]       exp2_reg;
    logic             zero2_reg;
    logic [2:0][23:0] mag2_reg;
    logic [2:0]       neg2_reg;
    sq_t              sq_reg [NORM_SQRT_STEPS+1];
    dv_t              dv_reg [NORM_DIV_STEPS+1];
    unit_vec_t        unit_reg;

    // One step of the digit-by-digit square root
    function automatic sq_t sqrt_step(input sq_t x, input logic [61:0] bitv);
        sq_t y;
        y = x;
        if (x.rem >= x.root + bitv) begin
            y.rem  = x.rem - (x.root + bitv);
            y.root = (x.root >> 1) + bitv;
        end else begin
            y.root = x.root >> 1;
        end
        return y;
    endfunction

    // One restoring quotient bit for all three components
    function automatic dv_t div_step(input dv_t x, input logic [3:0] sh);
        dv_t         y;
        logic [45:0] trial;
        y     = x;
        trial = 46'(x.q) << sh;
        for (int c = 0; c < 3; c++) begin
            if (x.rem[c] >= trial) begin
                y.rem[c]     = x.rem[c] - trial;
                y.quo[c][sh] = 1'b1;
            end
        end
        return y;
    endfunction

    // Magnitudes and squared length
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            neg_c[c] = comp_in[c][23];
            mag_c[c] = comp_in[c][23] ? 24'(-comp_in[c]) : 24'(comp_in[c]);
        end
        sum_c = 48'(mag_c[0]) * 48'(mag_c[0]) + 48'(mag_c[1]) * 48'(mag_c[1])
              + 48'(mag_c[2]) * 48'(mag_c[2]);
    end

    // Leading one of the squared length
    always_comb begin
        msb_c = '0;
        for (int b = 0; b < 48; b++) begin
            if (sum1_reg[b]) msb_c = 6'(b);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum1_reg <= sum_c;
            mag1_reg <= mag_c;
            neg1_reg <= neg_c;

            // shift count that lifts the length to at least 2^60
            sum2_reg  <= sum1_reg;
            exp2_reg  <= 5'((7'd61 - 7'(msb_c)) >> 1);
            zero2_reg <= (sum1_reg <= 48'(MIN_NORM_SQ));
            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;

            sq_reg[0].rem  <= 62'(sum2_reg) << {exp2_reg, 1'b0};
            sq_reg[0].root <= '0;
            sq_reg[0].mag  <= mag2_reg;
            sq_reg[0].neg  <= neg2_reg;
            sq_reg[0].expo <= exp2_reg;
            sq_reg[0].zero <= zero2_reg;

            for (int i = 0; i < NORM_SQRT_STEPS; i++) begin
                sq_reg[i+1] <= sqrt_step(sq_reg[i], 62'(1) << (60 - 2 * i));
            end

            // scaled numerators for the division by the root
            for (int c = 0; c < 3; c++) begin
                dv_reg[0].rem[c] <= 46'(sq_reg[NORM_SQRT_STEPS].mag[c])
                                    << (6'd14 + 6'(sq_reg[NORM_SQRT_STEPS].expo));
            end
            dv_reg[0].quo  <= '0;
            dv_reg[0].q    <= 31'(sq_reg[NORM_SQRT_STEPS].root);
            dv_reg[0].neg  <= sq_reg[NORM_SQRT_STEPS].neg;
            dv_reg[0].zero <= sq_reg[NORM_SQRT_STEPS].zero;

            for (int k = 0; k < NORM_DIV_STEPS; k++) begin
                dv_reg[k+1] <= div_step(dv_reg[k], 4'(NORM_DIV_STEPS - 1 - k));
            end

            // restore signs, short vectors read as zero
            for (int c = 0; c < 3; c++) begin
                if (dv_reg[NORM_DIV_STEPS].zero) begin
                    unit_reg[c] <= '0;
                end else if (dv_reg[NORM_DIV_STEPS].neg[c]) begin
                    unit_reg[c] <= 16'(-{1'b0, dv_reg[NORM_DIV_STEPS].quo[c]});
                end else begin
                    unit_reg[c] <= {1'b0, dv_reg[NORM_DIV_STEPS].quo[c]};
                end
            end
        end
    end

    assign unit_out = unit_reg;

endmodule

FILE: hdl/pls_falloff.sv
module pls_falloff
    import pls_pkg::*;
(
    input  logic     aclk,
    input  logic     en,
    input  logic     falloff_on,
    input  raw_vec_t lvec_in,
    input  rgb_t     rad_in,
    output rgb_t     rad_out
);

    typedef struct packed {
        logic [35:0]             d;
        logic [2:0][35:0]        rem;
        logic [2:0][FALL_QW-1:0] quo;
        rgb_t                    rad;
    } fdv_t;

    logic [2:0][23:0] mag_c;
    logic [47:0]      sum_c;
    logic [35:0]      dist_c;

    logic [47:0] sum1_reg;
    rgb_t        rad1_reg;
    fdv_t        fdv_reg [FALL_QW+1];
    rgb_t        rad_reg;

    function automatic fdv_t fdiv_step(input fdv_t x, input logic [FALL_SW-1:0] sh);
        fdv_t              y;
        logic [FALL_DW-1:0] trial;
        y     = x;
        trial = FALL_DW'(x.d) << sh;
        for (int c = 0; c < 3; c++) begin
            if (FALL_DW'(x.rem[c]) >= trial) begin
                y.rem[c]     = 36'(FALL_DW'(x.rem[c]) - trial);
                y.quo[c][sh] = 1'b1;
            end
        end
        return y;
    endfunction

    function automatic logic [23:0] sat24(input logic [FALL_QW-1:0] v);
        logic [35:0] vx;
        vx = 36'(v);
        return (vx > 36'(MAX_OUT)) ? MAX_OUT : vx[23:0];
    endfunction

    // Squared distance of the light
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            mag_c[c] = lvec_in[c][23] ? 24'(-lvec_in[c]) : 24'(lvec_in[c]);
        end
        sum_c = 48'(mag_c[0]) * 48'(mag_c[0]) + 48'(mag_c[1]) * 48'(mag_c[1])
              + 48'(mag_c[2]) * 48'(mag_c[2]);
    end

    // Squared distance in Q24.12, clamped from below
    always_comb begin
        dist_c = 36'(sum1_reg >> 12);
        if (dist_c < 36'(MIN_DIST_SQ)) dist_c = 36'(MIN_DIST_SQ);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum1_reg <= sum_c;
            rad1_reg <= rad_in;

            fdv_reg[0].d <= dist_c;
            for (int c = 0; c < 3; c++) begin
                fdv_reg[0].rem[c] <= {rad1_reg[c], 12'b0};
            end
            fdv_reg[0].quo <= '0;
            fdv_reg[0].rad <= rad1_reg;

            for (int k = 0; k < FALL_QW; k++) begin
                fdv_reg[k+1] <= fdiv_step(fdv_reg[k], FALL_SW'(FALL_QW - 1 - k));
            end

            for (int c = 0; c < 3; c++) begin
                rad_reg[c] <= falloff_on ? sat24(fdv_reg[FALL_QW].quo[c])
                                         : fdv_reg[FALL_QW].rad[c];
            end
        end
    end

    assign rad_out = rad_reg;

endmodule

FILE: hdl/pls_power.sv
module pls_power
    import pls_pkg::*;
(
    input  logic        aclk,
    input  logic        en,
    input  logic [15:0] base_in,
    input  logic [15:0] shine_in,
    output logic [15:0] spec_out
);

    typedef struct packed {
        logic [15:0] acc;
        logic [15:0] b;
        logic [15:0] x;
    } pi_t;

    typedef struct packed {
        logic [15:0] acc;
        logic [31:0] rem;
        logic [31:0] r;
    } fr_t;

    logic [15:0] expo;
    pi_t         pi_reg [POW_INT_BITS+1];
    fr_t         fr_reg [POW_FRAC_BITS][POW_ROOT_STEPS+1];
    logic [15:0] spec_reg;

    function automatic logic [15:0] mul_q15(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] p;
        p = 32'(a) * 32'(b);
        return 16'(p >> 15);
    endfunction

    function automatic fr_t root_step(input fr_t x, input logic [31:0] bitv);
        fr_t y;
        y = x;
        if (x.rem >= x.r + bitv) begin
            y.rem = x.rem - (x.r + bitv);
            y.r   = (x.r >> 1) + bitv;
        end else begin
            y.r = x.r >> 1;
        end
        return y;
    endfunction

    // Exponents below 1.0 count as 1.0
    assign expo = (shine_in < 16'd256) ? 16'd256 : shine_in;

    always_ff @(posedge aclk) begin
        if (en) begin
            pi_reg[0].acc <= ONE_Q15;
            pi_reg[0].b   <= base_in;
            pi_reg[0].x   <= base_in;

            // integer part: square and multiply from bit 0 up
            for (int k = 0; k < POW_INT_BITS; k++) begin
                pi_reg[k+1].acc <= expo[8+k] ? mul_q15(pi_reg[k].acc, pi_reg[k].b)
                                             : pi_reg[k].acc;
                pi_reg[k+1].b   <= mul_q15(pi_reg[k].b, pi_reg[k].b);
                pi_reg[k+1].x   <= pi_reg[k].x;
            end

            // fraction bits: repeated roots, each folded in on its bit
            fr_reg[0][0].acc <= pi_reg[POW_INT_BITS].acc;
            fr_reg[0][0].rem <= {1'b0, pi_reg[POW_INT_BITS].x, 15'b0};
            fr_reg[0][0].r   <= '0;
            for (int k = 1; k < POW_FRAC_BITS; k++) begin
                fr_reg[k][0].acc <= expo[8-k]
                    ? mul_q15(fr_reg[k-1][POW_ROOT_STEPS].acc,
                              fr_reg[k-1][POW_ROOT_STEPS].r[15:0])
                    : fr_reg[k-1][POW_ROOT_STEPS].acc;
                fr_reg[k][0].rem <= {fr_reg[k-1][POW_ROOT_STEPS].r[16:0], 15'b0};
                fr_reg[k][0].r   <= '0;
            end
            for (int k = 0; k < POW_FRAC_BITS; k++) begin
                for (int j = 0; j < POW_ROOT_STEPS; j++) begin
                    fr_reg[k][j+1] <= root_step(fr_reg[k][j], 32'(1) << (30 - 2 * j));
                end
            end

            spec_reg <= expo[0]
                ? mul_q15(fr_reg[POW_FRAC_BITS-1][POW_ROOT_STEPS].acc,
                          fr_reg[POW_FRAC_BITS-1][POW_ROOT_STEPS].r[15:0])
                : fr_reg[POW_FRAC_BITS-1][POW_ROOT_STEPS].acc;
        end
    end

    assign spec_out = spec_reg;

endmodule

FILE: hdl/phong_light_shader_top.sv
// Phong light shader, one shading sample in, one RGB contribution out.
// Input stream s_*: a sample is transferred when s_tvalid and s_tready are
// high at a rising edge of aclk. Result stream m_*: one result per sample,
// in order. Configuration: cfg_index selects the register, cfg_data carries
// it; cfg_ready is always high. Write configuration only while no sample is
// in flight.
// Throughput: one sample per cycle while the skid register is free. The
// pipeline depth is set by the pipelined square roots and dividers in the
// normalisers and by the eight repeated roots of the specular power unit.
// Reset (aresetn low at an edge) empties the pipeline and the output stage
// and loads the material registers with their defaults.
// When the receiver stalls, the pipeline keeps moving until a second result
// is waiting; the extra one sits in a skid register and s_tready falls until
// the receiver takes a result.
module phong_light_shader_top
    import pls_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // normal_x/y/z (16 each), to_light_x/y/z (24 each), view_x/y/z (16 each),
    // radiance_red/green/blue (24 each)
    input  logic [239:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // shade_red, shade_green, shade_blue (24 each)
    output logic [71:0]  m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam int FALL_PAD  = NORM_LAT - FALL_LAT;
    localparam int TOTAL_LAT = NORM_LAT + 3 + POW_LAT + 3;

    typedef struct packed {
        logic [15:0] lam;
        rgb_t        rad;
    } pd_t;

    logic [2:0][15:0] diffuse_reg;
    logic [2:0][15:0] specular_reg;
    logic [15:0]      shine_reg;
    logic             light_kind_reg;

    logic en;
    logic take;

    raw_vec_t  n_raw, l_raw, v_raw;
    rgb_t      rad_in;
    unit_vec_t n_u, l_u, v_u;
    rgb_t      fall_out;
    rgb_t      rad_dly_reg [FALL_PAD];

    logic [TOTAL_LAT-1:0] vline_reg;

    logic signed [31:0] nl_c;
    logic signed [19:0] r_c [3];
    logic signed [37:0] vr_c;

    unit_vec_t          n_d1_reg, l_d1_reg, v_d1_reg;
    logic signed [31:0] nl_d1_reg;
    rgb_t               rad_d1_reg;
    unit_vec_t          v_d2_reg;
    logic signed [19:0] r_d2_reg [3];
    logic [15:0]        lam_d2_reg;
    rgb_t               rad_d2_reg;
    logic [15:0]        base_d3_reg;
    pd_t                pd_d3_reg;
    pd_t                pd_reg [POW_LAT];
    logic [15:0]        spec;

    logic [2:0][33:0] term_reg;
    rgb_t             rad_f1_reg;
    logic [2:0][40:0] ph_reg, pl_reg;
    logic [57:0]      tot_c [3];
    logic [27:0]      shd_c [3];
    rgb_t             res_reg;

    rgb_t out_reg, skid_reg;
    logic out_v_reg, skid_v_reg;
    logic pop;

    function automatic logic [15:0] to_q15(input logic signed [37:0] d);
        logic [37:0] t;
        t = 38'(d >>> 13);
        if (d <= 38'sd0) return '0;
        if (t > 38'(ONE_Q15)) return ONE_Q15;
        return t[15:0];
    endfunction

    // Configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diffuse_reg    <= {3{ONE_Q15}};
            specular_reg   <= {3{ONE_Q15}};
            shine_reg      <= 16'd8192;
            light_kind_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DIFFUSE_RED:    diffuse_reg[0]  <= cfg_data;
                REG_DIFFUSE_GREEN:  diffuse_reg[1]  <= cfg_data;
                REG_DIFFUSE_BLUE:   diffuse_reg[2]  <= cfg_data;
                REG_SPECULAR_RED:   specular_reg[0] <= cfg_data;
                REG_SPECULAR_GREEN: specular_reg[1] <= cfg_data;
                REG_SPECULAR_BLUE:  specular_reg[2] <= cfg_data;
                REG_SHINE_EXPONENT: shine_reg       <= cfg_data;
                REG_LIGHT_KIND:     light_kind_reg  <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Pipeline moves whenever the skid register is free
    assign en       = !skid_v_reg;
    assign s_tready = en;
    assign take     = en && vline_reg[TOTAL_LAT-1];

    // Unpack the input transfer
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_raw[i]  = 24'($signed(s_tdata[16*i +: 16]));
            l_raw[i]  = $signed(s_tdata[48 + 24*i +: 24]);
            v_raw[i]  = 24'($signed(s_tdata[120 + 16*i +: 16]));
            rad_in[i] = s_tdata[168 + 24*i +: 24];
        end
    end

    pls_unit_vec u_norm_n (.aclk(aclk), .en(en), .comp_in(n_raw), .unit_out(n_u));
    pls_unit_vec u_norm_l (.aclk(aclk), .en(en), .comp_in(l_raw), .unit_out(l_u));
    pls_unit_vec u_norm_v (.aclk(aclk), .en(en), .comp_in(v_raw), .unit_out(v_u));

    pls_falloff u_falloff (
        .aclk       (aclk),
        .en         (en),
        .falloff_on (light_kind_reg),
        .lvec_in    (l_raw),
        .rad_in     (rad_in),
        .rad_out    (fall_out)
    );

    // Valid bits alongside the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vline_reg <= '0;
        end else if (en) begin
            vline_reg <= {vline_reg[TOTAL_LAT-2:0], s_tvalid};
        end
    end

    // Dot products and reflection
    always_comb begin
        nl_c = n_u[0] * l_u[0] + n_u[1] * l_u[1] + n_u[2] * l_u[2];
        for (int i = 0; i < 3; i++) begin
            r_c[i] = 20'((48'(nl_d1_reg) * 48'(n_d1_reg[i]) <<< 1) >>> 28)
                   - 20'(l_d1_reg[i]);
        end
        vr_c = v_d2_reg[0] * r_d2_reg[0] + v_d2_reg[1] * r_d2_reg[1]
             + v_d2_reg[2] * r_d2_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // falloff result waits for the normalisers
            rad_dly_reg[0] <= fall_out;
            for (int j = 1; j < FALL_PAD; j++) rad_dly_reg[j] <= rad_dly_reg[j-1];

            n_d1_reg   <= n_u;
            l_d1_reg   <= l_u;
            v_d1_reg   <= v_u;
            nl_d1_reg  <= nl_c;
            rad_d1_reg <= rad_dly_reg[FALL_PAD-1];

            v_d2_reg   <= v_d1_reg;
            r_d2_reg   <= r_c;
            lam_d2_reg <= to_q15(38'(nl_d1_reg));
            rad_d2_reg <= rad_d1_reg;

            base_d3_reg   <= to_q15(vr_c);
            pd_d3_reg.lam <= lam_d2_reg;
            pd_d3_reg.rad <= rad_d2_reg;

            // lambert and radiance wait for the power unit
            pd_reg[0] <= pd_d3_reg;
            for (int j = 1; j < POW_LAT; j++) pd_reg[j] <= pd_reg[j-1];

            for (int i = 0; i < 3; i++) begin
                term_reg[i] <= 34'(diffuse_reg[i]) * 34'(pd_reg[POW_LAT-1].lam)
                             + 34'(specular_reg[i]) * 34'(spec);
            end
            rad_f1_reg <= pd_reg[POW_LAT-1].rad;

            for (int i = 0; i < 3; i++) begin
                ph_reg[i] <= 41'(rad_f1_reg[i]) * 41'(term_reg[i][33:17]);
                pl_reg[i] <= 41'(rad_f1_reg[i]) * 41'(term_reg[i][16:0]);
            end

            for (int i = 0; i < 3; i++) begin
                res_reg[i] <= (shd_c[i] > 28'(MAX_OUT)) ? MAX_OUT : shd_c[i][23:0];
            end
        end
    end

    pls_power u_power (
        .aclk     (aclk),
        .en       (en),
        .base_in  (base_d3_reg),
        .shine_in (shine_reg),
        .spec_out (spec)
    );

    // Recombine the split product and scale back to Q12.12
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            tot_c[i] = (58'(ph_reg[i]) << 17) + 58'(pl_reg[i]);
            shd_c[i] = 28'(tot_c[i] >> 30);
        end
    end

    // Output register with one skid entry
    assign pop = out_v_reg && m_tready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (skid_v_reg) begin
            if (pop) begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
        end else if (take) begin
            if (!out_v_reg || pop) begin
                out_v_reg <= 1'b1;
            end else begin
                skid_v_reg <= 1'b1;
            end
        end else if (pop) begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_v_reg) begin
            if (pop) out_reg <= skid_reg;
        end else if (take) begin
            if (!out_v_reg || pop) begin
                out_reg <= res_reg;
            end else begin
                skid_reg <= res_reg;
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

    // The skid entry is only ever filled behind a held output
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> out_v_reg)
        else $error("skid entry valid with output register empty");

    // A result arriving at a held output must land in the skid entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        take && out_v_reg && !m_tready |=> skid_v_reg)
        else $error("result dropped while output stalled");

    // Reset empties the output side and reopens the input
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output side not empty after reset");

endmodule
